// ===== rtl/frustum_sphere_cull_defines.svh =====
// Assertion macros used by the checker file.
`ifndef FRUSTUM_SPHERE_CULL_DEFINES_SVH
`define FRUSTUM_SPHERE_CULL_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FSC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: label failed");
// Next-cycle implication checked on every clock edge outside reset.
`define FSC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: label failed");
`endif

// ===== rtl/fsc_pkg.sv =====
// Package: types, state codes and plane selection for frustum sphere culling.
`default_nettype none
package fsc_pkg;
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SQRT,
    ST_DIV,
    ST_NEXT,
    ST_TEST,
    ST_DONE
  } state_t;

  function automatic logic [1:0] sel_row(input logic [2:0] p);
    case (p)
      3'd0, 3'd1: sel_row = 2'd0;
      3'd2, 3'd3: sel_row = 2'd1;
      default:    sel_row = 2'd2;
    endcase
  endfunction

  function automatic logic sel_neg(input logic [2:0] p);
    case (p)
      3'd1, 3'd2, 3'd5: sel_neg = 1'b1;
      default:          sel_neg = 1'b0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== rtl/fsc_if.sv =====
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface fsc_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [1:0]  column;
  logic signed [31:0] col_x;
  logic signed [31:0] col_y;
  logic signed [31:0] col_z;
  logic signed [31:0] col_w;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [30:0] radius;
  modport source (output valid, func, column, col_x, col_y, col_z, col_w,
                  pos_x, pos_y, pos_z, radius, input ready);
  modport sink (input valid, func, column, col_x, col_y, col_z, col_w,
                pos_x, pos_y, pos_z, radius, output ready);
endinterface

interface fsc_res_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic planes_built;
  modport source (output valid, inside_res, planes_built, input ready);
  modport sink (input valid, inside_res, planes_built, output ready);
endinterface
`default_nettype wire

// ===== rtl/fsc_seq.sv =====
// Sequencer and shared arithmetic unit: square root, division, dot product.
`default_nettype none
module fsc_seq #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  fsc_req_if.sink  req,
  fsc_res_if.source res
);
  import fsc_pkg::*;

  localparam int QW = 34 + FRAC_BITS;

  state_t state, state_next;
  logic signed [31:0] mat [16];
  logic signed [31:0] pl  [24];
  logic [5:0] usable;
  logic built;

  logic [2:0] p;
  logic [2:0] k;
  logic [5:0] bit_i;
  logic signed [32:0] comp [4];
  logic [65:0] sum;
  logic [32:0] root;
  logic [QW-1:0] rem, quo, dvd;
  logic signed [31:0] ppx, ppy, ppz;
  logic [30:0] prad;
  logic touch;
  logic signed [65:0] acc;
  logic res_valid;
  logic res_load;

  logic [32:0] cmag;
  logic [32:0] cand;
  logic [65:0] csq;
  logic [QW:0] rem_sh;
  logic [QW-1:0] q_sat;
  logic signed [31:0] dval;
  logic signed [63:0] prod;
  logic signed [65:0] pdist, lim;

  assign req.ready = (state == ST_IDLE);
  assign res.valid = res_valid;
  assign res_load = (state == ST_DONE) && (!res_valid || res.ready);

  always_comb begin
    cmag = comp[k[1:0]][32] ? 33'(-comp[k[1:0]]) : 33'(comp[k[1:0]]);
    cand = root | (33'd1 << bit_i);
    csq = 66'(cand) * 66'(cand);
    rem_sh = {rem, dvd[QW-1]};
    if (comp[k[1:0]][32])
      q_sat = (quo > QW'(64'h80000000)) ? QW'(64'h80000000) : quo;
    else
      q_sat = (quo > QW'(64'h7FFFFFFF)) ? QW'(64'h7FFFFFFF) : quo;
    dval = comp[k[1:0]][32] ? 32'(-q_sat) : q_sat[31:0];
    case (k[1:0])
      2'd0:    prod = pl[{p, 2'd0}] * ppx;
      2'd1:    prod = pl[{p, 2'd1}] * ppy;
      default: prod = pl[{p, 2'd2}] * ppz;
    endcase
    pdist = acc + (66'(pl[{p, 2'd3}]) <<< FRAC_BITS);
    lim = -(66'(prad) <<< FRAC_BITS);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req.valid && req.ready) begin
        if (req.func) state_next = ST_TEST;
        else if (req.column == 2'd3) state_next = ST_SUM;
      end
      ST_SUM:  if (k == 3'd3) state_next = ST_SQRT;
      ST_SQRT: if (bit_i == 6'd0) state_next = ST_DIV;
      ST_DIV:  if (k == 3'd3 && (root == '0 || bit_i == 6'(QW))) state_next = ST_NEXT;
      ST_NEXT: state_next = (p == 3'd5) ? ST_IDLE : ST_SUM;
      ST_TEST: if (k == 3'd3 && (p == 3'd5)) state_next = ST_DONE;
      ST_DONE: if (res_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      usable <= '0;
      built <= 1'b0;
      res_valid <= 1'b0;
      for (int i = 0; i < 16; i++) mat[i] <= '0;
      for (int i = 0; i < 24; i++) pl[i] <= '0;
    end else begin
      state <= state_next;
      if (res_load) res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;
      case (state)
        ST_IDLE: if (req.valid && req.ready) begin
          p <= '0; k <= '0; sum <= '0; acc <= '0; touch <= 1'b1;
          ppx <= req.pos_x; ppy <= req.pos_y; ppz <= req.pos_z;
          prad <= req.radius;
          if (!req.func) begin
            mat[{req.column, 2'd0}] <= req.col_x;
            mat[{req.column, 2'd1}] <= req.col_y;
            mat[{req.column, 2'd2}] <= req.col_z;
            mat[{req.column, 2'd3}] <= req.col_w;
            if (req.column == 2'd3) begin
              for (int i = 0; i < 3; i++)
                comp[i] <= 33'(mat[i*4+3]) + 33'(mat[i*4]);
              comp[3] <= 33'(req.col_w) + 33'(req.col_x);
            end
          end
        end
        ST_SUM: begin
          if (k != 3'd3) sum <= sum + 66'(cmag) * 66'(cmag);
          k <= (k == 3'd3) ? 3'd0 : k + 3'd1;
          root <= '0;
          bit_i <= 6'd32;
        end
        ST_SQRT: begin
          if (csq <= sum) root <= cand;
          if (bit_i == 6'd0) begin
            bit_i <= 6'(QW - 1);
            rem <= '0; quo <= '0;
            dvd <= QW'(cmag) << FRAC_BITS;
          end else bit_i <= bit_i - 6'd1;
        end
        ST_DIV: begin
          if (root == '0) begin
            pl[{p, k[1:0]}] <= '0;
            bit_i <= '0;
            k <= (k == 3'd3) ? 3'd0 : k + 3'd1;
            if (k != 3'd3) dvd <= '0;
          end else if (bit_i == 6'd0) begin
            if (rem_sh >= (QW+1)'(root)) quo <= {quo[QW-2:0], 1'b1};
            else quo <= {quo[QW-2:0], 1'b0};
            bit_i <= 6'(QW);
          end else if (bit_i == 6'(QW)) begin
            pl[{p, k[1:0]}] <= dval;
            k <= (k == 3'd3) ? 3'd0 : k + 3'd1;
            bit_i <= 6'(QW - 1);
            rem <= '0; quo <= '0;
            dvd <= QW'(comp[k[1:0] + 2'd1][32] ? 33'(-comp[k[1:0] + 2'd1])
                                               : 33'(comp[k[1:0] + 2'd1])) << FRAC_BITS;
          end else begin
            if (rem_sh >= (QW+1)'(root)) begin
              rem <= QW'(rem_sh - (QW+1)'(root));
              quo <= {quo[QW-2:0], 1'b1};
            end else begin
              rem <= rem_sh[QW-1:0];
              quo <= {quo[QW-2:0], 1'b0};
            end
            dvd <= dvd << 1;
            bit_i <= bit_i - 6'd1;
          end
        end
        ST_NEXT: begin
          usable[p] <= root != '0;
          sum <= '0;
          k <= '0;
          if (p == 3'd5) built <= 1'b1;
          else begin
            p <= p + 3'd1;
            for (int i = 0; i < 4; i++)
              comp[i] <= sel_neg(p + 3'd1)
                ? 33'(mat[i*4+3]) - 33'(mat[i*4+sel_row(p + 3'd1)])
                : 33'(mat[i*4+3]) + 33'(mat[i*4+sel_row(p + 3'd1)]);
          end
        end
        ST_TEST: begin
          if (k == 3'd3) begin
            if (usable[p] && pdist <= lim) touch <= 1'b0;
            acc <= '0;
            k <= '0;
            p <= p + 3'd1;
          end else begin
            acc <= acc + 66'(prod);
            k <= k + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.inside_res <= touch;
      res.planes_built <= built;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/frustum_sphere_cull.sv =====
// Sphere test: the six planes are tested in turn (x, y and z products, then offset and compare);
// the result is registered in ST_DONE. Load of column 0..2: one per cycle while idle. Column 3
// rebuilds planes serially and stays busy; a plane with a zero-length normal gets zero coefficients.
// Throughput: one request at a time; a finished result waits in the output register.
// Reset (rst, synchronous) clears matrix, planes, usable and built flags.
`default_nettype none
module frustum_sphere_cull #(
  parameter int FRAC_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  fsc_req_if.sink  req,
  fsc_res_if.source res
);
  fsc_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (.clk(clk), .rst(rst), .req(req), .res(res));
endmodule
`default_nettype wire

// ===== rtl/fsc_checker.sv =====
// Port-level checker bound to the top level.
`default_nettype none
`include "frustum_sphere_cull_defines.svh"
module fsc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       req_func,
  input wire logic [1:0] req_column,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       res_inside
);
  `FSC_ASSERT_NXT(a_load_ready, clk, rst, req_valid && req_ready && !req_func && req_column != 2'd3, req_ready)
  `FSC_ASSERT_NXT(a_busy_after_test, clk, rst, req_valid && req_ready && req_func, !req_ready)
  `FSC_ASSERT_NXT(a_res_holds, clk, rst, res_valid && !res_ready, res_valid && $stable(res_inside))
endmodule

bind frustum_sphere_cull fsc_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .req_func(req.func), .req_column(req.column), .res_valid(res.valid),
  .res_ready(res.ready), .res_inside(res.inside_res)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for frustum_sphere_cull: matrix loads, plane rebuilds, sphere tests.
`default_nettype none
module tb;
  import fsc_pkg::*;

  localparam int FRAC = 16;
  localparam logic FN_LOAD = 1'b0;
  localparam logic FN_TEST = 1'b1;
  localparam logic [1:0] COL_W = 2'd3;
  localparam int ONE = 1 << FRAC;
  localparam int WATCH_LIMIT = 20000;
  localparam int LONG_STALL = 400;

  typedef struct {
    logic        func;
    logic [1:0]  column;
    logic [31:0] col [4];
    logic [31:0] pos [3];
    logic [30:0] radius;
    bit          hold;
  } request_t;

  typedef struct {
    logic inside_res;
    logic planes_built;
  } verdict_t;

  logic clk;
  logic rst;
  fsc_req_if req_ch ();
  fsc_res_if res_ch ();

  frustum_sphere_cull #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .req(req_ch), .res(res_ch)
  );

  request_t pending_q[$];
  verdict_t verdict_q[$];
  int n_pending;
  int n_res;
  int n_loads;
  int n_rebuilds;
  int n_culled;
  int errors;
  int gap;
  int burst;
  int stall_cnt;
  bit stalled_once;
  int phase_cnt;
  int idle_cyc;

  // predictor state
  logic [31:0] mat [16];
  logic [31:0] pln [24];
  bit usable [6];
  bit built;
  int row_of [6] = '{0, 0, 1, 1, 2, 2};
  bit neg_of [6] = '{0, 1, 1, 0, 0, 1};

  function automatic logic [33:0] root_floor(input logic [67:0] s);
    logic [33:0] r;
    logic [33:0] cand;
    logic [69:0] sq;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = r | (34'd1 << b);
      sq = 70'(cand) * 70'(cand);
      if (sq <= 70'(s)) r = cand;
    end
    return r;
  endfunction

  function automatic logic [31:0] norm_div(input longint v, input logic [33:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v < 0 ? 64'(-v) : 64'(v);
    q = (mag << FRAC) / 64'(len);
    if (v < 0) return q > 64'h8000_0000 ? 32'h8000_0000 : 32'(-q);
    return q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic void rebuild_planes();
    longint comp [4];
    logic [67:0] s;
    logic [33:0] len;
    longint m;
    for (int p = 0; p < 6; p++) begin
      s = '0;
      for (int k = 0; k < 4; k++) begin
        longint w;
        longint e;
        w = longint'($signed(mat[k*4+3]));
        e = longint'($signed(mat[k*4+row_of[p]]));
        comp[k] = neg_of[p] ? w - e : w + e;
      end
      for (int k = 0; k < 3; k++) begin
        m = comp[k] < 0 ? -comp[k] : comp[k];
        s = s + 68'(m) * 68'(m);
      end
      len = root_floor(s);
      usable[p] = len != 0;
      for (int k = 0; k < 4; k++) pln[p*4+k] = len != 0 ? norm_div(comp[k], len) : 32'd0;
    end
    built = 1;
  endfunction

  function automatic bit sphere_touches(input request_t r);
    logic signed [127:0] pdist;
    logic signed [127:0] lim;
    logic signed [127:0] c [4];
    logic signed [127:0] q [3];
    lim = -(128'(r.radius) <<< FRAC);
    for (int i = 0; i < 3; i++) q[i] = 128'($signed(r.pos[i]));
    for (int p = 0; p < 6; p++) begin
      if (usable[p]) begin
        for (int k = 0; k < 4; k++) c[k] = 128'($signed(pln[p*4+k]));
        pdist = c[0]*q[0] + c[1]*q[1] + c[2]*q[2] + (c[3] <<< FRAC);
        if (pdist <= lim) return 0;
      end
    end
    return 1;
  endfunction

  function automatic logic [31:0] rand_elem();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return $urandom;
    if (sel == 1) return 32'd0;
    return 32'($urandom_range(0, 8 * ONE) - 4 * ONE);
  endfunction

  function automatic void add_load(input logic [1:0] c, input logic [31:0] x,
                                   input logic [31:0] y, input logic [31:0] z,
                                   input logic [31:0] w);
    request_t r;
    r.func = FN_LOAD; r.column = c; r.hold = 0;
    r.col = '{x, y, z, w};
    r.pos = '{$urandom, $urandom, $urandom};
    r.radius = 31'($urandom);
    pending_q.push_back(r);
  endfunction

  function automatic void add_test(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] z, input logic [30:0] rad);
    request_t r;
    r.func = FN_TEST; r.column = 2'($urandom); r.hold = 0;
    r.col = '{$urandom, $urandom, $urandom, $urandom};
    r.pos = '{x, y, z};
    r.radius = rad;
    pending_q.push_back(r);
  endfunction

  function automatic void add_hold();
    request_t r;
    r = '{default: '0};
    r.hold = 1;
    pending_q.push_back(r);
  endfunction

  initial begin
    clk = 0;
    rst = 1;
    req_ch.valid = 0; req_ch.func = 0; req_ch.column = 0;
    req_ch.col_x = 0; req_ch.col_y = 0; req_ch.col_z = 0; req_ch.col_w = 0;
    req_ch.pos_x = 0; req_ch.pos_y = 0; req_ch.pos_z = 0; req_ch.radius = 0;
    res_ch.ready = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 16; i++) mat[i] = 0;
    for (int i = 0; i < 24; i++) pln[i] = 0;
    for (int i = 0; i < 6; i++) usable[i] = 0;
    built = 0;
    // no planes yet
    add_test(0, 0, 0, 0);
    add_test(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    // all-zero matrix: every normal has zero length
    add_load(COL_W, 0, 0, 0, 0);
    add_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    // identity, columns before w do not rebuild
    add_load(2'd0, ONE, 0, 0, 0);
    add_load(2'd1, 0, ONE, 0, 0);
    add_load(2'd2, 0, 0, ONE, 0);
    add_test(-3 * ONE, 0, 0, 0);
    add_load(COL_W, 0, 0, 0, ONE);
    add_test(0, 0, 0, 0);
    add_test(-3 * ONE, 0, 0, 31'(ONE));
    add_test(-2 * ONE, 0, 0, 31'(ONE));
    add_test(-2 * ONE, 0, 0, 31'(ONE + 1));
    add_test(0, 0, 5 * ONE, 0);
    add_test(0, 2 * ONE, 0, 31'(ONE));
    add_test(32'h8000_0000, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF);
    // tiny normals with a huge offset saturate d
    add_load(2'd0, 1, 0, 0, 0);
    add_load(2'd1, 0, 1, 0, 0);
    add_load(2'd2, 0, 0, 1, 0);
    add_load(COL_W, 0, 0, 0, 32'h7FFF_FFFF);
    add_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    add_load(COL_W, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    add_test(32'h7FFF_FFFF, 0, 32'h8000_0000, 31'h7FFF_FFFF);
    add_hold();
    for (int n = 0; n < 550; n++) begin
      if (n == 300) add_hold();
      if ($urandom_range(0, 99) < 9) begin
        add_load($urandom_range(0, 99) < 30 ? COL_W : 2'($urandom_range(0, 2)),
                 rand_elem(), rand_elem(), rand_elem(), rand_elem());
      end else if ($urandom_range(0, 19) == 0) begin
        add_test($urandom, $urandom, $urandom, 31'($urandom));
      end else begin
        add_test(32'($urandom_range(0, 32 * ONE) - 16 * ONE),
                 32'($urandom_range(0, 32 * ONE) - 16 * ONE),
                 32'($urandom_range(0, 32 * ONE) - 16 * ONE),
                 31'($urandom_range(0, 8 * ONE)));
      end
    end
    repeat (8) @(posedge clk);
    rst <= 0;
    wait (pending_q.size() == 0 && !req_ch.valid && n_pending == 0 && req_ch.ready);
    repeat (60) @(posedge clk);
    $display("tb: %0d sphere tests (%0d culled), %0d column loads, %0d plane rebuilds",
             n_res, n_culled, n_loads, n_rebuilds);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    request_t r;
    if (rst) begin
      req_ch.valid <= 0;
      gap <= 0;
      burst <= 4;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (gap > 0) begin
        gap <= gap - 1;
        req_ch.valid <= 0;
      end else if (pending_q.size() != 0 && pending_q[0].hold) begin
        req_ch.valid <= 0;
        if (n_pending == 0) void'(pending_q.pop_front());
      end else if (pending_q.size() != 0) begin
        r = pending_q.pop_front();
        req_ch.valid <= 1;
        req_ch.func <= r.func;
        req_ch.column <= r.column;
        req_ch.col_x <= r.col[0];
        req_ch.col_y <= r.col[1];
        req_ch.col_z <= r.col[2];
        req_ch.col_w <= r.col[3];
        req_ch.pos_x <= r.pos[0];
        req_ch.pos_y <= r.pos[1];
        req_ch.pos_z <= r.pos[2];
        req_ch.radius <= r.radius;
        if (burst <= 1) begin
          burst <= $urandom_range(1, 12);
          gap <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
        end else begin
          burst <= burst - 1;
        end
      end else begin
        req_ch.valid <= 0;
      end
    end
  end

  // result sink stall pattern
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 0;
      stall_cnt <= 0;
      stalled_once <= 0;
      phase_cnt <= 0;
    end else begin
      phase_cnt <= phase_cnt + 1;
      if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        res_ch.ready <= 0;
      end else if (!stalled_once && n_res >= 60) begin
        stalled_once <= 1;
        stall_cnt <= LONG_STALL;
        res_ch.ready <= 0;
      end else if (phase_cnt[7:6] == 2'd0) begin
        res_ch.ready <= 1;
      end else begin
        res_ch.ready <= $urandom_range(0, 3) != 0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    request_t r;
    verdict_t v;
    int push;
    int pop;
    if (rst) begin
      n_pending <= 0;
      n_res <= 0;
    end else begin
      push = 0;
      pop = 0;
      if (res_ch.valid && res_ch.ready) begin
        pop = 1;
        n_res <= n_res + 1;
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result inside=%0b built=%0b", $time,
                   res_ch.inside_res, res_ch.planes_built);
        end else begin
          v = verdict_q.pop_front();
          if (!v.inside_res) n_culled++;
          if (res_ch.inside_res !== v.inside_res) begin
            errors++;
            $display("%0t: inside_res expected %0b actual %0b", $time,
                     v.inside_res, res_ch.inside_res);
          end
          if (res_ch.planes_built !== v.planes_built) begin
            errors++;
            $display("%0t: planes_built expected %0b actual %0b", $time,
                     v.planes_built, res_ch.planes_built);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        r.func = req_ch.func;
        r.column = req_ch.column;
        r.col = '{req_ch.col_x, req_ch.col_y, req_ch.col_z, req_ch.col_w};
        r.pos = '{req_ch.pos_x, req_ch.pos_y, req_ch.pos_z};
        r.radius = req_ch.radius;
        if (r.func == FN_TEST) begin
          v.inside_res = sphere_touches(r);
          v.planes_built = built;
          verdict_q.push_back(v);
          push = 1;
        end else begin
          n_loads++;
          for (int k = 0; k < 4; k++) mat[r.column*4+k] = r.col[k];
          if (r.column == COL_W) begin
            rebuild_planes();
            n_rebuilds++;
          end
        end
      end
      n_pending <= n_pending + push - pop;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WATCH_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, n_pending);
      $display("tb: errors");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end
endmodule
`default_nettype wire
